/* sv/ffha_pkg.sv */
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned MaxBlocks   = 64;
  localparam int unsigned HeapBytes   = 65536;
  localparam int unsigned HeaderBytes = 32;
  localparam int unsigned MinPayload  = 8;
  localparam int unsigned IdxW        = $clog2(MaxBlocks);
  localparam int unsigned LinkW       = IdxW + 1;
  localparam int unsigned TopW        = $clog2(HeapBytes) + 1;
  localparam int unsigned SizeW       = 17;
  localparam int unsigned TotW        = 18;
  localparam int unsigned ResW        = 12;

  localparam logic [LinkW-1:0] NoSlot = LinkW'(MaxBlocks);

  localparam logic [1:0] ActAlloc   = 2'd0;
  localparam logic [1:0] ActFree    = 2'd1;
  localparam logic [1:0] ActRealloc = 2'd2;
  localparam logic [1:0] ActUnused  = 2'd3;

  localparam logic [1:0] StDone   = 2'd0;
  localparam logic [1:0] StNull   = 2'd1;
  localparam logic [1:0] StNoHeap = 2'd2;
  localparam logic [1:0] StNoSlot = 2'd3;

  typedef struct packed {
    logic [15:0]      start;
    logic [15:0]      bytes;
    logic             free;
    logic [LinkW-1:0] fwd;
    logic [LinkW-1:0] bwd;
  } entry_t;

  typedef struct packed {
    logic [IdxW-1:0]  rd_idx;
    logic             wr_en;
    logic [IdxW-1:0]  wr_idx;
    entry_t           wr_data;
    logic             set_en;
    logic [IdxW-1:0]  set_idx;
    logic             clr_en;
    logic [IdxW-1:0]  clr_idx;
    logic             first_we;
    logic [LinkW-1:0] first_d;
    logic             last_we;
    logic [LinkW-1:0] last_d;
    logic             top_we;
    logic [TopW-1:0]  top_d;
  } dp_cmd_t;

  typedef struct packed {
    entry_t           rdata;
    logic [MaxBlocks-1:0] busy;
    logic [IdxW-1:0]  free_idx;
    logic             any_free;
    logic [LinkW-1:0] list_first;
    logic [LinkW-1:0] list_last;
    logic [TopW-1:0]  heap_top;
    logic [ResW-1:0]  reserve;
  } dp_stat_t;

endpackage

/* sv/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator with split and coalescing.
//
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   action_i, request_bytes_i, payload_address_i
//   out      out_valid_o / out_ready_i result_address_o, status_o, copy_source_o,
//                                      copy_bytes_o
//   cfg      cfg_valid_i / cfg_ready_o extend_reserve_i
//
// One item is worked at a time through the block table memory, which has one
// read and one write port. An address lookup scans the table slots in order and
// stops at the matching block; an allocation walks the block list at one entry
// per cycle, up to 64 entries, before it splits the block or extends the heap.
// Reset clears the slot bitmap and list registers at once; no clearing pass.
// A waiting result is held in the output register while the next item is taken.
module first_fit_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] payload_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_address_o,
  output logic [1:0]  status_o,
  output logic [15:0] copy_source_o,
  output logic [15:0] copy_bytes_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [11:0] extend_reserve_i
);

  ffha_pkg::dp_cmd_t  cmd;
  ffha_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ffha_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .request_bytes_i   (request_bytes_i),
    .payload_address_i (payload_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_address_o  (result_address_o),
    .status_o          (status_o),
    .copy_source_o     (copy_source_o),
    .copy_bytes_o      (copy_bytes_o),
    .cmd_o             (cmd),
    .stat_i            (stat)
  );

  ffha_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (extend_reserve_i),
    .stat_o     (stat)
  );

endmodule

/* sv/ffha_dpath.sv */
// Datapath of the allocator: block table memory, slot bitmap and list registers.
module ffha_dpath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ffha_pkg::dp_cmd_t      cmd_i,
  input  logic                   cfg_we_i,
  input  logic [ffha_pkg::ResW-1:0] cfg_data_i,
  output ffha_pkg::dp_stat_t     stat_o
);

  ffha_pkg::entry_t mem [ffha_pkg::MaxBlocks];
  ffha_pkg::entry_t rdata_q;
  logic [ffha_pkg::MaxBlocks-1:0] busy_q;
  logic [ffha_pkg::LinkW-1:0] first_q, last_q;
  logic [ffha_pkg::TopW-1:0] top_q;
  logic [ffha_pkg::ResW-1:0] reserve_q;
  logic [ffha_pkg::IdxW-1:0] free_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_idx] <= cmd_i.wr_data;
    end
    rdata_q <= mem[cmd_i.rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      first_q   <= ffha_pkg::NoSlot;
      last_q    <= ffha_pkg::NoSlot;
      top_q     <= '0;
      reserve_q <= '0;
    end else begin
      if (cmd_i.set_en) begin
        busy_q[cmd_i.set_idx] <= 1'b1;
      end
      if (cmd_i.clr_en) begin
        busy_q[cmd_i.clr_idx] <= 1'b0;
      end
      if (cmd_i.first_we) begin
        first_q <= cmd_i.first_d;
      end
      if (cmd_i.last_we) begin
        last_q <= cmd_i.last_d;
      end
      if (cmd_i.top_we) begin
        top_q <= cmd_i.top_d;
      end
      if (cfg_we_i) begin
        reserve_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = ffha_pkg::MaxBlocks - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_idx = ffha_pkg::IdxW'(i);
      end
    end
  end

  assign stat_o.rdata      = rdata_q;
  assign stat_o.busy       = busy_q;
  assign stat_o.free_idx   = free_idx;
  assign stat_o.any_free   = ~&busy_q;
  assign stat_o.list_first = first_q;
  assign stat_o.list_last  = last_q;
  assign stat_o.heap_top   = top_q;
  assign stat_o.reserve    = reserve_q;

endmodule

/* sv/ffha_ctrl.sv */
// Controller of the allocator: sequencer for search, split, merge and extension.
module ffha_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             action_i,
  input  logic [15:0]            request_bytes_i,
  input  logic [15:0]            payload_address_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [15:0]            result_address_o,
  output logic [1:0]             status_o,
  output logic [15:0]            copy_source_o,
  output logic [15:0]            copy_bytes_o,
  output ffha_pkg::dp_cmd_t      cmd_o,
  input  ffha_pkg::dp_stat_t     stat_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_FIND, S_FREE_CHK, S_RE_CHK, S_RE_MERGED, S_RE_INPLACE, S_RE_MOVED,
    S_RE_LOAD, S_ALLOC_FIN, S_A0, S_A1, S_EXT, S_EXT1, S_TAKE, S_SP0, S_SP1,
    S_SP2, S_M0, S_M1, S_M2, S_R0, S_R1, S_R2, S_DONE
  } state_e;

  localparam int unsigned IdxW  = ffha_pkg::IdxW;
  localparam int unsigned LinkW = ffha_pkg::LinkW;
  localparam int unsigned SizeW = ffha_pkg::SizeW;
  localparam int unsigned TotW  = ffha_pkg::TotW;
  localparam int unsigned TopW  = ffha_pkg::TopW;

  state_e state_q, state_d;
  state_e ret_alloc_q, ret_alloc_d, ret_split_q, ret_split_d;
  state_e ret_merge_q, ret_merge_d, ret_rel_q, ret_rel_d;
  logic [1:0] act_q, act_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [15:0] addr_q, addr_d;
  logic [1:0] status_q, status_d;
  logic [15:0] result_q, result_d, csrc_q, csrc_d, cbytes_q, cbytes_d;
  logic [15:0] old_bytes_q, old_bytes_d, bstart_q, bstart_d;
  logic [IdxW-1:0] ob_q, ob_d, ib_q, ib_d, ir_q, ir_d, ip_q, ip_d;
  ffha_pkg::entry_t eb_q, eb_d, er, nx;
  logic [LinkW-1:0] cur_q, cur_d, n_q, n_d;
  logic [IdxW:0] k_q, k_d;
  logic pend_q, pend_d, found_q, found_d, ok_q, ok_d;
  logic out_valid_q, out_valid_d;
  logic [15:0] out_res_q, out_res_d, out_src_q, out_src_d, out_cb_q, out_cb_d;
  logic [1:0] out_st_q, out_st_d;
  ffha_pkg::dp_cmd_t cmd;

  logic [SizeW-1:0] size_rnd;
  logic [TotW-1:0] total;
  logic fits;
  logic [SizeW-1:0] blk_end;

  assign size_rnd = ({1'b0, request_bytes_i} + SizeW'(7)) & ~SizeW'(7);
  assign total = TotW'(ffha_pkg::HeaderBytes) + TotW'(size_q) + TotW'(stat_i.reserve);
  assign fits = !(TotW'(stat_i.heap_top) > TotW'(ffha_pkg::HeapBytes)) &&
                !(total > (TotW'(ffha_pkg::HeapBytes) - TotW'(stat_i.heap_top)));
  assign blk_end = {1'b0, eb_q.start} + SizeW'(ffha_pkg::HeaderBytes) + {1'b0, eb_q.bytes};

  always_comb begin
    state_d = state_q;
    ret_alloc_d = ret_alloc_q;
    ret_split_d = ret_split_q;
    ret_merge_d = ret_merge_q;
    ret_rel_d = ret_rel_q;
    act_d = act_q;
    size_d = size_q;
    addr_d = addr_q;
    status_d = status_q;
    result_d = result_q;
    csrc_d = csrc_q;
    cbytes_d = cbytes_q;
    old_bytes_d = old_bytes_q;
    bstart_d = bstart_q;
    ob_d = ob_q;
    ib_d = ib_q;
    ir_d = ir_q;
    ip_d = ip_q;
    eb_d = eb_q;
    cur_d = cur_q;
    n_d = n_q;
    k_d = k_q;
    pend_d = pend_q;
    found_d = found_q;
    ok_d = ok_q;
    out_valid_d = out_valid_q;
    out_res_d = out_res_q;
    out_src_d = out_src_q;
    out_cb_d = out_cb_q;
    out_st_d = out_st_q;
    er = eb_q;
    nx = stat_i.rdata;
    cmd = '0;
    cmd.wr_idx = ib_q;
    cmd.wr_data = eb_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = action_i;
          size_d = size_rnd;
          addr_d = payload_address_i;
          status_d = ffha_pkg::StNull;
          result_d = '0;
          csrc_d = '0;
          cbytes_d = '0;
          ok_d = 1'b0;
          k_d = '0;
          pend_d = 1'b0;
          case (action_i)
            ffha_pkg::ActAlloc: begin
              if (size_rnd == '0) begin
                state_d = S_DONE;
              end else begin
                ret_alloc_d = S_ALLOC_FIN;
                state_d = S_A0;
              end
            end
            ffha_pkg::ActFree, ffha_pkg::ActRealloc: state_d = S_FIND;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_FIND: begin
        if (pend_q && stat_i.busy[cur_q[IdxW-1:0]] &&
            ({1'b0, stat_i.rdata.start} + SizeW'(ffha_pkg::HeaderBytes)) ==
            {1'b0, addr_q}) begin
          ib_d = cur_q[IdxW-1:0];
          eb_d = stat_i.rdata;
          found_d = 1'b1;
          state_d = (act_q == ffha_pkg::ActFree) ? S_FREE_CHK : S_RE_CHK;
        end else if (k_q == (IdxW+1)'(ffha_pkg::MaxBlocks)) begin
          found_d = 1'b0;
          state_d = (act_q == ffha_pkg::ActFree) ? S_FREE_CHK : S_RE_CHK;
        end else begin
          cmd.rd_idx = k_q[IdxW-1:0];
          cur_d = LinkW'(k_q);
          pend_d = 1'b1;
          k_d = k_q + 1'b1;
        end
      end
      S_FREE_CHK: begin
        if (found_q && !eb_q.free) begin
          ret_rel_d = S_DONE;
          state_d = S_R0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RE_CHK: begin
        if (size_q == '0) begin
          if (found_q && !eb_q.free) begin
            ret_rel_d = S_DONE;
            state_d = S_R0;
          end else begin
            state_d = S_DONE;
          end
        end else if (!(found_q && !eb_q.free)) begin
          ret_alloc_d = S_ALLOC_FIN;
          state_d = S_A0;
        end else begin
          old_bytes_d = eb_q.bytes;
          ret_merge_d = S_RE_MERGED;
          state_d = S_M0;
        end
      end
      S_RE_MERGED: begin
        if (size_q <= {1'b0, eb_q.bytes}) begin
          ret_split_d = S_RE_INPLACE;
          state_d = S_SP0;
        end else begin
          bstart_d = eb_q.start;
          ob_d = ib_q;
          ret_alloc_d = S_RE_MOVED;
          state_d = S_A0;
        end
      end
      S_RE_INPLACE: begin
        result_d = eb_q.start + 16'(ffha_pkg::HeaderBytes);
        status_d = ffha_pkg::StDone;
        state_d = S_DONE;
      end
      S_RE_MOVED: begin
        if (ok_q) begin
          result_d = eb_q.start + 16'(ffha_pkg::HeaderBytes);
          csrc_d = bstart_q + 16'(ffha_pkg::HeaderBytes);
          cbytes_d = old_bytes_q;
          cmd.rd_idx = ob_q;
          state_d = S_RE_LOAD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RE_LOAD: begin
        eb_d = stat_i.rdata;
        ib_d = ob_q;
        ret_rel_d = S_DONE;
        state_d = S_R0;
      end
      S_ALLOC_FIN: begin
        if (ok_q) begin
          result_d = eb_q.start + 16'(ffha_pkg::HeaderBytes);
        end
        state_d = S_DONE;
      end
      S_A0: begin
        k_d = '0;
        if (stat_i.list_first >= ffha_pkg::NoSlot) begin
          state_d = S_EXT;
        end else begin
          cmd.rd_idx = stat_i.list_first[IdxW-1:0];
          cur_d = stat_i.list_first;
          state_d = S_A1;
        end
      end
      S_A1: begin
        eb_d = stat_i.rdata;
        ib_d = cur_q[IdxW-1:0];
        if (stat_i.rdata.free && ({1'b0, stat_i.rdata.bytes} >= size_q)) begin
          ret_split_d = S_TAKE;
          state_d = S_SP0;
        end else if ((k_q + 1'b1) == (IdxW+1)'(ffha_pkg::MaxBlocks) ||
                     stat_i.rdata.fwd >= ffha_pkg::NoSlot) begin
          state_d = S_EXT;
        end else begin
          k_d = k_q + 1'b1;
          cmd.rd_idx = stat_i.rdata.fwd[IdxW-1:0];
          cur_d = stat_i.rdata.fwd;
        end
      end
      S_EXT: begin
        if (!fits) begin
          status_d = ffha_pkg::StNoHeap;
          ok_d = 1'b0;
          state_d = ret_alloc_q;
        end else if (!stat_i.any_free) begin
          status_d = ffha_pkg::StNoSlot;
          ok_d = 1'b0;
          state_d = ret_alloc_q;
        end else begin
          cmd.set_en = 1'b1;
          cmd.set_idx = stat_i.free_idx;
          er.start = stat_i.heap_top[15:0];
          er.bytes = 16'(size_q + SizeW'(stat_i.reserve));
          er.free = 1'b0;
          er.fwd = ffha_pkg::NoSlot;
          cmd.top_we = 1'b1;
          cmd.top_d = stat_i.heap_top + TopW'(total);
          cmd.last_we = 1'b1;
          cmd.last_d = LinkW'(stat_i.free_idx);
          ib_d = stat_i.free_idx;
          ret_split_d = S_TAKE;
          if (stat_i.list_first >= ffha_pkg::NoSlot ||
              stat_i.list_last >= ffha_pkg::NoSlot) begin
            cmd.first_we = 1'b1;
            cmd.first_d = LinkW'(stat_i.free_idx);
            er.bwd = ffha_pkg::NoSlot;
            state_d = S_SP0;
          end else begin
            er.bwd = stat_i.list_last;
            cmd.rd_idx = stat_i.list_last[IdxW-1:0];
            ip_d = stat_i.list_last[IdxW-1:0];
            state_d = S_EXT1;
          end
          eb_d = er;
          cmd.wr_en = 1'b1;
          cmd.wr_idx = stat_i.free_idx;
          cmd.wr_data = er;
        end
      end
      S_EXT1: begin
        nx.fwd = LinkW'(ib_q);
        cmd.wr_en = 1'b1;
        cmd.wr_idx = ip_q;
        cmd.wr_data = nx;
        state_d = S_SP0;
      end
      S_TAKE: begin
        eb_d.free = 1'b0;
        cmd.wr_en = 1'b1;
        cmd.wr_data = eb_d;
        status_d = ffha_pkg::StDone;
        ok_d = 1'b1;
        state_d = ret_alloc_q;
      end
      S_SP0: begin
        if ({2'b00, eb_q.bytes} < (TotW'(size_q) +
            TotW'(ffha_pkg::HeaderBytes + ffha_pkg::MinPayload))) begin
          state_d = ret_split_q;
        end else if (!stat_i.any_free) begin
          state_d = ret_split_q;
        end else begin
          cmd.set_en = 1'b1;
          cmd.set_idx = stat_i.free_idx;
          er.start = 16'({1'b0, eb_q.start} + SizeW'(ffha_pkg::HeaderBytes) + size_q);
          er.bytes = 16'({1'b0, eb_q.bytes} - size_q - SizeW'(ffha_pkg::HeaderBytes));
          er.free = 1'b1;
          er.bwd = LinkW'(ib_q);
          er.fwd = eb_q.fwd;
          cmd.wr_en = 1'b1;
          cmd.wr_idx = stat_i.free_idx;
          cmd.wr_data = er;
          ir_d = stat_i.free_idx;
          n_d = eb_q.fwd;
          eb_d.fwd = LinkW'(stat_i.free_idx);
          eb_d.bytes = 16'(size_q);
          state_d = S_SP1;
        end
      end
      S_SP1: begin
        cmd.wr_en = 1'b1;
        if (n_q >= ffha_pkg::NoSlot) begin
          cmd.last_we = 1'b1;
          cmd.last_d = LinkW'(ir_q);
          state_d = ret_split_q;
        end else begin
          cmd.rd_idx = n_q[IdxW-1:0];
          state_d = S_SP2;
        end
      end
      S_SP2: begin
        nx.bwd = LinkW'(ir_q);
        cmd.wr_en = 1'b1;
        cmd.wr_idx = n_q[IdxW-1:0];
        cmd.wr_data = nx;
        state_d = ret_split_q;
      end
      S_M0: begin
        n_d = eb_q.fwd;
        if (eb_q.fwd >= ffha_pkg::NoSlot) begin
          state_d = ret_merge_q;
        end else begin
          cmd.rd_idx = eb_q.fwd[IdxW-1:0];
          state_d = S_M1;
        end
      end
      S_M1: begin
        if (!stat_i.rdata.free || blk_end != {1'b0, stat_i.rdata.start}) begin
          state_d = ret_merge_q;
        end else begin
          eb_d.bytes = 16'({1'b0, eb_q.bytes} + SizeW'(ffha_pkg::HeaderBytes) +
                           {1'b0, stat_i.rdata.bytes});
          eb_d.fwd = stat_i.rdata.fwd;
          cmd.wr_en = 1'b1;
          cmd.wr_data = eb_d;
          cmd.clr_en = 1'b1;
          cmd.clr_idx = n_q[IdxW-1:0];
          if (stat_i.rdata.fwd >= ffha_pkg::NoSlot) begin
            cmd.last_we = 1'b1;
            cmd.last_d = LinkW'(ib_q);
            state_d = ret_merge_q;
          end else begin
            cmd.rd_idx = stat_i.rdata.fwd[IdxW-1:0];
            n_d = stat_i.rdata.fwd;
            state_d = S_M2;
          end
        end
      end
      S_M2: begin
        nx.bwd = LinkW'(ib_q);
        cmd.wr_en = 1'b1;
        cmd.wr_idx = n_q[IdxW-1:0];
        cmd.wr_data = nx;
        state_d = ret_merge_q;
      end
      S_R0: begin
        eb_d.free = 1'b1;
        cmd.wr_en = 1'b1;
        cmd.wr_data = eb_d;
        ret_merge_d = S_R1;
        state_d = S_M0;
      end
      S_R1: begin
        if (eb_q.bwd >= ffha_pkg::NoSlot) begin
          state_d = ret_rel_q;
        end else begin
          cmd.rd_idx = eb_q.bwd[IdxW-1:0];
          ip_d = eb_q.bwd[IdxW-1:0];
          state_d = S_R2;
        end
      end
      S_R2: begin
        if (stat_i.rdata.free) begin
          eb_d = stat_i.rdata;
          ib_d = ip_q;
          ret_merge_d = ret_rel_q;
          state_d = S_M0;
        end else begin
          state_d = ret_rel_q;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_res_d = result_q;
          out_st_d = status_q;
          out_src_d = csrc_q;
          out_cb_d = cbytes_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_alloc_q <= S_IDLE;
      ret_split_q <= S_IDLE;
      ret_merge_q <= S_IDLE;
      ret_rel_q <= S_IDLE;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_alloc_q <= ret_alloc_d;
      ret_split_q <= ret_split_d;
      ret_merge_q <= ret_merge_d;
      ret_rel_q <= ret_rel_d;
      pend_q <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    size_q <= size_d;
    addr_q <= addr_d;
    status_q <= status_d;
    result_q <= result_d;
    csrc_q <= csrc_d;
    cbytes_q <= cbytes_d;
    old_bytes_q <= old_bytes_d;
    bstart_q <= bstart_d;
    ob_q <= ob_d;
    ib_q <= ib_d;
    ir_q <= ir_d;
    ip_q <= ip_d;
    eb_q <= eb_d;
    cur_q <= cur_d;
    n_q <= n_d;
    k_q <= k_d;
    found_q <= found_d;
    ok_q <= ok_d;
    out_res_q <= out_res_d;
    out_src_q <= out_src_d;
    out_cb_q <= out_cb_d;
    out_st_q <= out_st_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_address_o = out_res_q;
  assign status_o = out_st_q;
  assign copy_source_o = out_src_q;
  assign copy_bytes_o = out_cb_q;
  assign cmd_o = cmd;

endmodule

/* verif/first_fit_heap_allocator_checker.sv */
// Checker that predicts and compares the allocator's results.
`timescale 1ns / 1ps
module first_fit_heap_allocator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] payload_address_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] result_address_i,
  input  logic [1:0]  status_i,
  input  logic [15:0] copy_source_i,
  input  logic [15:0] copy_bytes_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [11:0] extend_reserve_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  status;
    logic [15:0] csrc;
    logic [15:0] cbytes;
  } outcome_t;

  int unsigned blk_start [ffha_pkg::MaxBlocks];
  int unsigned blk_bytes [ffha_pkg::MaxBlocks];
  bit          blk_free  [ffha_pkg::MaxBlocks];
  int unsigned blk_next  [ffha_pkg::MaxBlocks];
  int unsigned blk_prev  [ffha_pkg::MaxBlocks];
  bit          blk_used  [ffha_pkg::MaxBlocks];
  int unsigned head_blk, tail_blk, top_bytes, reserve_bytes;
  outcome_t    expected_q[$];

  function automatic int unsigned take_slot();
    for (int unsigned i = 0; i < ffha_pkg::MaxBlocks; i++) begin
      if (!blk_used[i]) begin
        blk_used[i] = 1'b1;
        return i;
      end
    end
    return ffha_pkg::MaxBlocks;
  endfunction

  function automatic int unsigned lookup_block(int unsigned addr);
    for (int unsigned i = 0; i < ffha_pkg::MaxBlocks; i++) begin
      if (blk_used[i] && blk_start[i] + ffha_pkg::HeaderBytes == addr) return i;
    end
    return ffha_pkg::MaxBlocks;
  endfunction

  function automatic void carve(int unsigned b, int unsigned size);
    int unsigned r, n;
    if (blk_bytes[b] < size + ffha_pkg::HeaderBytes + ffha_pkg::MinPayload) return;
    r = take_slot();
    if (r >= ffha_pkg::MaxBlocks) return;
    blk_start[r] = blk_start[b] + ffha_pkg::HeaderBytes + size;
    blk_bytes[r] = blk_bytes[b] - size - ffha_pkg::HeaderBytes;
    blk_free[r] = 1'b1;
    blk_prev[r] = b;
    n = blk_next[b];
    blk_next[r] = n;
    if (n < ffha_pkg::MaxBlocks) blk_prev[n] = r;
    else tail_blk = r;
    blk_next[b] = r;
    blk_bytes[b] = size;
  endfunction

  function automatic void absorb_next(int unsigned b);
    int unsigned n, nn;
    n = blk_next[b];
    if (n >= ffha_pkg::MaxBlocks || !blk_free[n]) return;
    if (blk_start[b] + ffha_pkg::HeaderBytes + blk_bytes[b] != blk_start[n]) return;
    blk_bytes[b] += ffha_pkg::HeaderBytes + blk_bytes[n];
    nn = blk_next[n];
    blk_next[b] = nn;
    if (nn < ffha_pkg::MaxBlocks) blk_prev[nn] = b;
    else tail_blk = b;
    blk_used[n] = 1'b0;
  endfunction

  function automatic void give_back(int unsigned b);
    int unsigned p;
    blk_free[b] = 1'b1;
    absorb_next(b);
    p = blk_prev[b];
    if (p < ffha_pkg::MaxBlocks && blk_free[p]) absorb_next(p);
  endfunction

  function automatic int unsigned place_block(int unsigned size, output logic [1:0] st);
    int unsigned b, total;
    b = head_blk;
    for (int unsigned k = 0; k < ffha_pkg::MaxBlocks && b < ffha_pkg::MaxBlocks; k++) begin
      if (blk_free[b] && blk_bytes[b] >= size) begin
        carve(b, size);
        blk_free[b] = 1'b0;
        st = ffha_pkg::StDone;
        return b;
      end
      b = blk_next[b];
    end
    total = ffha_pkg::HeaderBytes + size + reserve_bytes;
    if (top_bytes > ffha_pkg::HeapBytes || total > ffha_pkg::HeapBytes - top_bytes) begin
      st = ffha_pkg::StNoHeap;
      return ffha_pkg::MaxBlocks;
    end
    b = take_slot();
    if (b >= ffha_pkg::MaxBlocks) begin
      st = ffha_pkg::StNoSlot;
      return ffha_pkg::MaxBlocks;
    end
    blk_start[b] = top_bytes;
    top_bytes += total;
    blk_bytes[b] = size + reserve_bytes;
    blk_free[b] = 1'b0;
    blk_next[b] = ffha_pkg::MaxBlocks;
    if (head_blk >= ffha_pkg::MaxBlocks || tail_blk >= ffha_pkg::MaxBlocks) begin
      head_blk = b;
      blk_prev[b] = ffha_pkg::MaxBlocks;
    end else begin
      blk_prev[b] = tail_blk;
      blk_next[tail_blk] = b;
    end
    tail_blk = b;
    carve(b, size);
    st = ffha_pkg::StDone;
    return b;
  endfunction

  function automatic outcome_t predict_outcome(logic [1:0] act, logic [15:0] req,
                                               logic [15:0] addr);
    outcome_t o;
    int unsigned size, b, nb, old_bytes;
    logic [1:0] st;
    size = (int'(req) + 7) & ~7;
    o = '{addr: '0, status: ffha_pkg::StNull, csrc: '0, cbytes: '0};
    if (act == ffha_pkg::ActAlloc) begin
      if (size != 0) begin
        nb = place_block(size, st);
        o.status = st;
        if (nb < ffha_pkg::MaxBlocks) o.addr = 16'(blk_start[nb] + ffha_pkg::HeaderBytes);
      end
    end else if (act == ffha_pkg::ActFree) begin
      b = lookup_block(addr);
      if (b < ffha_pkg::MaxBlocks && !blk_free[b]) give_back(b);
    end else if (act == ffha_pkg::ActRealloc) begin
      b = lookup_block(addr);
      if (b < ffha_pkg::MaxBlocks && blk_free[b]) b = ffha_pkg::MaxBlocks;
      if (size == 0) begin
        if (b < ffha_pkg::MaxBlocks) give_back(b);
      end else if (b >= ffha_pkg::MaxBlocks) begin
        nb = place_block(size, st);
        o.status = st;
        if (nb < ffha_pkg::MaxBlocks) o.addr = 16'(blk_start[nb] + ffha_pkg::HeaderBytes);
      end else begin
        old_bytes = blk_bytes[b];
        absorb_next(b);
        if (size <= blk_bytes[b]) begin
          carve(b, size);
          o.addr = 16'(blk_start[b] + ffha_pkg::HeaderBytes);
          o.status = ffha_pkg::StDone;
        end else begin
          nb = place_block(size, st);
          o.status = st;
          if (nb < ffha_pkg::MaxBlocks) begin
            o.addr = 16'(blk_start[nb] + ffha_pkg::HeaderBytes);
            o.csrc = 16'(blk_start[b] + ffha_pkg::HeaderBytes);
            o.cbytes = 16'(old_bytes);
            give_back(b);
          end
        end
      end
    end
    return o;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_o;
    if (!rst_ni) begin
      for (int i = 0; i < ffha_pkg::MaxBlocks; i++) blk_used[i] = 1'b0;
      head_blk = ffha_pkg::MaxBlocks;
      tail_blk = ffha_pkg::MaxBlocks;
      top_bytes = 0;
      reserve_bytes = 0;
      expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) reserve_bytes = extend_reserve_i;
      if (in_valid_i && in_ready_i)
        expected_q.push_back(predict_outcome(action_i, request_bytes_i, payload_address_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item: addr %0d status %0d", result_address_i, status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_o = expected_q.pop_front();
          if (exp_o != {result_address_i, status_i, copy_source_i, copy_bytes_i}) begin
            if (exp_o.addr != result_address_i)
              $error("result_address: expected %0d actual %0d", exp_o.addr, result_address_i);
            if (exp_o.status != status_i)
              $error("status: expected %0d actual %0d", exp_o.status, status_i);
            if (exp_o.csrc != copy_source_i)
              $error("copy_source: expected %0d actual %0d", exp_o.csrc, copy_source_i);
            if (exp_o.cbytes != copy_bytes_i)
              $error("copy_bytes: expected %0d actual %0d", exp_o.cbytes, copy_bytes_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* verif/first_fit_heap_allocator_tb.sv */
// Testbench top: stimulus, reserve settings and verdict for the allocator.
`timescale 1ns / 1ps
module first_fit_heap_allocator_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [15:0] request_bytes_i = '0;
  logic [15:0] payload_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] result_address_o;
  logic [1:0]  status_o;
  logic [15:0] copy_source_o;
  logic [15:0] copy_bytes_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [11:0] extend_reserve_i = '0;
  int          fail_count;
  int          pending;
  logic [15:0] live_addrs[$];
  bit          sink_on = 1'b0;

  always #4 clk_i = ~clk_i;

  first_fit_heap_allocator dut (.*);

  first_fit_heap_allocator_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i,
    .request_bytes_i, .payload_address_i, .out_valid_i(out_valid_o), .out_ready_i,
    .result_address_i(result_address_o), .status_i(status_o),
    .copy_source_i(copy_source_o), .copy_bytes_i(copy_bytes_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .extend_reserve_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i && status_o == ffha_pkg::StDone) begin
      if (live_addrs.size() < 80) live_addrs.push_back(result_address_o);
    end
  end

  initial begin
    int unsigned wait_cycles;
    forever begin
      @(posedge clk_i);
      if (!sink_on) begin
        out_ready_i <= 1'b1;
      end else if (!out_ready_i || out_valid_o) begin
        wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (wait_cycles == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (wait_cycles) @(posedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  task automatic send_item(logic [1:0] act, logic [15:0] req, logic [15:0] addr,
                           bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    request_bytes_i <= req;
    payload_address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reserve(logic [11:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    extend_reserve_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_address();
    int unsigned k;
    if (live_addrs.size() == 0 || $urandom_range(0, 9) == 0) return 16'($urandom());
    k = $urandom_range(0, live_addrs.size() - 1);
    pick_address = live_addrs[k];
    live_addrs.delete(k);
  endfunction

  task automatic random_phase(int unsigned count, int unsigned max_req);
    logic [1:0]  act;
    logic [15:0] req;
    for (int unsigned i = 0; i < count; i++) begin
      act = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 30) == 0) act = ffha_pkg::ActUnused;
      req = (i % 97 == 0) ? 16'($urandom()) : 16'($urandom_range(0, max_req));
      if ($urandom_range(0, 20) == 0) req = 16'd0;
      send_item(act, req, (act == ffha_pkg::ActAlloc) ? 16'($urandom()) : pick_address(),
                i % 150 > 20);
      if (i == count / 2) drain_results();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_item(ffha_pkg::ActAlloc, 16'd0, 16'd0, 0);
    send_item(ffha_pkg::ActAlloc, 16'd1, 16'd0, 0);
    send_item(ffha_pkg::ActAlloc, 16'd100, 16'd0, 0);
    send_item(ffha_pkg::ActAlloc, 16'd8, 16'd0, 0);
    send_item(ffha_pkg::ActFree, 16'd0, 16'd32, 0);
    send_item(ffha_pkg::ActAlloc, 16'd3, 16'd0, 0);
    send_item(ffha_pkg::ActRealloc, 16'd200, 16'd72, 0);
    send_item(ffha_pkg::ActRealloc, 16'd16, 16'hFFFF, 0);
    send_item(ffha_pkg::ActFree, 16'd0, 16'd0, 0);
    send_item(ffha_pkg::ActFree, 16'd0, 16'h1234, 0);
    send_item(ffha_pkg::ActUnused, 16'hFFFF, 16'hFFFF, 0);
    send_item(ffha_pkg::ActRealloc, 16'd0, 16'd32, 0);
    send_item(ffha_pkg::ActAlloc, 16'hFFFF, 16'd0, 0);
    send_item(ffha_pkg::ActAlloc, 16'hFFD0, 16'd0, 0);
    send_item(ffha_pkg::ActRealloc, 16'h8000, 16'd0, 0);
    sink_on = 1'b1;
    write_reserve(12'd2048);
    random_phase(150, 600);
    write_reserve(12'hFFF);
    random_phase(150, 300);
    write_reserve(12'd0);
    random_phase(300, 40);
    write_reserve(12'd64);
    random_phase(450, 900);
    drain_results();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
sv/ffha_pkg.sv
sv/ffha_dpath.sv
sv/ffha_ctrl.sv
sv/first_fit_heap_allocator.sv
verif/first_fit_heap_allocator_checker.sv
verif/first_fit_heap_allocator_tb.sv
